@@ rtl/rwt_pkg.sv @@
// shared types, widths and codes of the retransmit window table
package rwt_pkg;

    // window size and derived widths
    localparam int WINDOW_ENTRIES = 16;
    localparam int IDX_W = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(WINDOW_ENTRIES + 1);

    // field widths
    localparam int CMD_W   = 2;
    localparam int SEQ_W   = 32;
    localparam int STAMP_W = 48;
    localparam int TIME_W  = 32;
    localparam int FREE_W  = 5;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_TIMEOUT = 1'b0;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd2000000;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_RETX   = 1'b1;

    // event codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } command_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_READ,
        ST_EVAL,
        ST_AGE,
        ST_LEFT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic send_write;
        logic rd_en;
        logic eval;
        logic emit_retx;
        logic idx_inc;
        logic age_calc;
        logic emit_status;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_send;
        logic timed_out;
        logic last_idx;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/rwt_if.sv @@
// event and result channel interfaces
interface rwt_evt_if;
    import rwt_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [SEQ_W-1:0]   seq_number;
    logic [STAMP_W-1:0] now_us;

    modport source (output valid, output command, output seq_number, output now_us,
                    input ready);
    modport sink (input valid, input command, input seq_number, input now_us,
                  output ready);
endinterface

interface rwt_res_if;
    import rwt_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SEQ_W-1:0]  retransmit_seq;
    logic              accepted;
    logic [FREE_W-1:0] free_slots;
    logic [TIME_W-1:0] time_left_us;
    logic              last;

    modport source (output valid, output kind, output retransmit_seq, output accepted,
                    output free_slots, output time_left_us, output last, input ready);
    modport sink (input valid, input kind, input retransmit_seq, input accepted,
                  input free_slots, input time_left_us, input last, output ready);
endinterface

@@ rtl/rwt_cfg.sv @@
// timeout register behind the apb-style port
module rwt_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rwt_pkg::PADDR_W-1:0]  paddr,
    input  logic [rwt_pkg::PDATA_W-1:0]  pwdata,
    output logic [rwt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output logic [rwt_pkg::TIME_W-1:0]   timeout
);
    import rwt_pkg::*;

    logic [TIME_W-1:0] timeout_reg;
    logic [TIME_W-1:0] timeout_next;
    logic              hit;

    assign pready = 1'b1;
    assign hit    = (paddr[PADDR_W-1:2] == REG_TIMEOUT);

    // register write
    always_comb
    begin
        timeout_next = timeout_reg;
        if (psel && penable && pwrite && hit)
        begin
            timeout_next = pwdata[TIME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    // read back
    assign prdata  = hit ? timeout_reg : '0;
    assign timeout = timeout_reg;

endmodule

@@ rtl/rwt_ctrl.sv @@
// sequencer that walks the window one entry at a time
module rwt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 evt_valid,
    output logic                 evt_ready,
    input  rwt_pkg::dp_stat_t    stat,
    output rwt_pkg::ctrl_cmd_t   cmd
);
    import rwt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        evt_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                evt_ready = 1'b1;
                if (evt_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.is_send ? ST_SEND : ST_READ;
                end
            end
            ST_SEND:
            begin
                cmd.send_write = 1'b1;
                state_next     = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                // a due entry waits here until the result register is free
                if (!stat.timed_out || stat.out_free)
                begin
                    cmd.eval      = 1'b1;
                    cmd.emit_retx = stat.timed_out;
                    if (stat.last_idx)
                    begin
                        state_next = ST_AGE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_AGE:
            begin
                cmd.age_calc = 1'b1;
                state_next   = ST_LEFT;
            end
            ST_LEFT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rwt_datapath.sv @@
// entry storage, per-entry evaluation, status accumulation and result register
module rwt_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rwt_pkg::CMD_W-1:0]     evt_command,
    input  logic [rwt_pkg::SEQ_W-1:0]     evt_seq_number,
    input  logic [rwt_pkg::STAMP_W-1:0]   evt_now_us,
    input  logic [rwt_pkg::TIME_W-1:0]    timeout,
    input  rwt_pkg::ctrl_cmd_t            cmd,
    output rwt_pkg::dp_stat_t             stat,
    rwt_res_if.source                     res
);
    import rwt_pkg::*;

    // entry stores
    logic [SEQ_W-1:0]   seq_mem   [WINDOW_ENTRIES];
    logic [STAMP_W-1:0] stamp_mem [WINDOW_ENTRIES];
    logic [WINDOW_ENTRIES-1:0] valid_reg;
    logic [WINDOW_ENTRIES-1:0] valid_next;

    // event registers
    command_t           cmd_reg;
    logic [SEQ_W-1:0]   seq_in_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SEQ_W-1:0]   rd_seq_reg;
    logic [STAMP_W-1:0] rd_stamp_reg;

    // status accumulation
    logic               accepted_reg;
    logic [CNT_W-1:0]   free_cnt_reg;
    logic               any_reg;
    logic [STAMP_W-1:0] oldest_reg;
    logic [STAMP_W-1:0] age_reg;

    // result register
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic              out_acc_reg;
    logic [FREE_W-1:0] out_free_reg;
    logic [TIME_W-1:0] out_left_reg;
    logic              out_last_reg;

    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               cur_valid;
    logic [STAMP_W:0]   stamp_plus;
    logic               timed_out;
    logic               ack_clear;
    logic               post_valid;
    logic [STAMP_W-1:0] post_stamp;
    logic               post_older;
    logic               out_free;
    logic [TIME_W-1:0]  left;
    logic [CNT_W+FREE_W-1:0] free_wide;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;

    // lowest free entry
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WINDOW_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // evaluation of the entry just read
    assign cur_valid  = valid_reg[idx_reg];
    assign stamp_plus = {1'b0, rd_stamp_reg} + {{(STAMP_W + 1 - TIME_W){1'b0}}, timeout};
    assign timed_out  = (cmd_reg == CMD_TICK) && cur_valid && ({1'b0, now_reg} > stamp_plus);
    assign ack_clear  = (cmd_reg == CMD_ACK) && cur_valid && (rd_seq_reg < seq_in_reg);
    assign post_valid = cur_valid && !ack_clear;
    assign post_stamp = timed_out ? now_reg : rd_stamp_reg;
    assign post_older = timed_out ? (now_reg < oldest_reg) : (rd_stamp_reg < oldest_reg);

    assign out_free = !out_valid_reg || res.ready;

    assign stat.is_send   = (command_t'(evt_command) == CMD_SEND);
    assign stat.timed_out = timed_out;
    assign stat.last_idx  = (idx_reg == IDX_W'(WINDOW_ENTRIES - 1));
    assign stat.out_free  = out_free;

    // time left from the oldest stamp, saturated at zero
    always_comb
    begin
        left = '0;
        if (any_reg && (age_reg < {{(STAMP_W - TIME_W){1'b0}}, timeout}))
        begin
            left = timeout - age_reg[TIME_W-1:0];
        end
    end

    assign free_wide = {{FREE_W{1'b0}}, free_cnt_reg};

    // valid bit updates
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.send_write && free_found)
        begin
            valid_next[free_idx] = 1'b1;
        end
        if (cmd.eval && ack_clear)
        begin
            valid_next[idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry memories, one write and one registered read a cycle
    assign mem_we    = (cmd.send_write && free_found) || (cmd.eval && timed_out);
    assign mem_waddr = cmd.send_write ? free_idx : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.send_write && free_found)
        begin
            seq_mem[free_idx] <= seq_in_reg;
        end
        if (mem_we)
        begin
            stamp_mem[mem_waddr] <= now_reg;
        end
        if (cmd.rd_en)
        begin
            rd_seq_reg   <= seq_mem[idx_reg];
            rd_stamp_reg <= stamp_mem[idx_reg];
        end
    end

    // event capture, oldest stamp tracking and age calculation
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            seq_in_reg <= evt_seq_number;
            now_reg    <= evt_now_us;
        end
        if (cmd.eval && post_valid && (!any_reg || post_older))
        begin
            oldest_reg <= post_stamp;
        end
        if (cmd.age_calc)
        begin
            age_reg <= (now_reg >= oldest_reg) ? (now_reg - oldest_reg) : '0;
        end
    end

    // scan control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= CMD_NONE;
            idx_reg      <= '0;
            accepted_reg <= 1'b0;
            free_cnt_reg <= '0;
            any_reg      <= 1'b0;
        end
        else if (cmd.capture)
        begin
            cmd_reg      <= command_t'(evt_command);
            idx_reg      <= '0;
            accepted_reg <= 1'b0;
            free_cnt_reg <= '0;
            any_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.send_write)
            begin
                accepted_reg <= free_found;
            end
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.eval)
            begin
                if (!post_valid)
                begin
                    free_cnt_reg <= free_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    any_reg <= 1'b1;
                end
            end
        end
    end

    // result register handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_retx || cmd.emit_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_retx)
        begin
            out_kind_reg <= KIND_RETX;
            out_seq_reg  <= rd_seq_reg;
            out_acc_reg  <= 1'b0;
            out_free_reg <= '0;
            out_left_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_kind_reg <= KIND_STATUS;
            out_seq_reg  <= '0;
            out_acc_reg  <= accepted_reg;
            out_free_reg <= free_wide[FREE_W-1:0];
            out_left_reg <= left;
            out_last_reg <= 1'b1;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.kind           = out_kind_reg;
    assign res.retransmit_seq = out_seq_reg;
    assign res.accepted       = out_acc_reg;
    assign res.free_slots     = out_free_reg;
    assign res.time_left_us   = out_left_reg;
    assign res.last           = out_last_reg;

endmodule

@@ rtl/retransmit_window_table_unit.sv @@
// Sender-side retransmission window of WINDOW_ENTRIES outstanding packets with a
// timeout timer. Events arrive on evt: send stores a sequence and its timestamp in
// the lowest free entry, ack frees every entry whose sequence is below the given
// value, tick asks for a retransmission of each entry older than timeout_us and
// restamps it. Each event gives its retransmit requests in entry order, then one
// status result (last set) with the free-entry count and the time left until the
// earliest deadline. One event is handled at a time: a send first writes its entry,
// then every event walks the entry memories through their registered read port,
// reading and then evaluating each entry, computes the age of the oldest stamp and
// loads its status into the result register; a due entry or the status waits while
// the result register is still full and res.ready is low. A new event is taken as
// soon as the status is loaded, even if it is not yet taken. No clearing pass
// follows reset. The timeout sits at byte address 0 of the register port and
// resets to 2000000 microseconds.
module retransmit_window_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    rwt_evt_if.sink                      evt,
    rwt_res_if.source                    res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rwt_pkg::PADDR_W-1:0]  paddr,
    input  logic [rwt_pkg::PDATA_W-1:0]  pwdata,
    output logic [rwt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import rwt_pkg::*;

    logic [TIME_W-1:0] timeout;
    ctrl_cmd_t         ctrl_cmd;
    dp_stat_t          dp_stat;

    // configuration register
    rwt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timeout (timeout)
    );

    // sequencer
    rwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    // datapath
    rwt_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_command    (evt.command),
        .evt_seq_number (evt.seq_number),
        .evt_now_us     (evt.now_us),
        .timeout        (timeout),
        .cmd            (ctrl_cmd),
        .stat           (dp_stat),
        .res            (res)
    );

    // a retransmit request is only issued into a free result register
    a_retx_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.emit_retx |-> dp_stat.out_free)
        else $error("retransmit request issued over a pending result");

    // an accepted event blocks the next one, with ready low in the cycle after acceptance
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        (evt.valid && evt.ready) |=> !evt.ready)
        else $error("event accepted while another is in progress");

    // a status result shows up marked last
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.emit_status |=> (res.valid && res.last && res.kind == KIND_STATUS))
        else $error("status result not presented as last");

    // a retransmit request shows up not marked last
    a_retx_shape: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.emit_retx |=> (res.valid && !res.last && res.kind == KIND_RETX))
        else $error("retransmit request malformed");

endmodule
